// ===== hw/rtl/reb_pkg.sv =====
// Shared constants, types and helpers of the rotary encoder and button scanner.
package reb_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int OUT_POS_WIDTH  = 16;
    localparam int TICKS_WIDTH    = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 1;

    localparam logic [TICKS_WIDTH-1:0] LONG_PRESS_RESET = TICKS_WIDTH'(1000);
    localparam logic                   A_IDLE_LEVEL     = 1'b1;
    localparam logic                   KEY_DOWN         = 1'b0;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_LONG_PRESS_TICKS = 1'b0,
        CFG_STEP_ON_RISING   = 1'b1
    } cfg_index_t;

    typedef logic signed [POSITION_WIDTH-1:0] position_t;
    typedef logic signed [OUT_POS_WIDTH-1:0]  out_position_t;

    typedef struct packed {
        logic pressed;
        logic long_held;
    } key_status_t;

    typedef struct packed {
        logic      step_cw;
        logic      step_ccw;
        logic      moved;
        position_t x_next;
        position_t y_next;
    } quad_result_t;

    // Sign-extend a counter and cut it to the width of the result field.
    function automatic out_position_t pos_out(input position_t v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[OUT_POS_WIDTH-1:0];
    endfunction

endpackage

// ===== hw/rtl/reb_in_if.sv =====
// Request channel carrying one tick sample of the encoder and button pins.
interface reb_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic pin_key;

    modport source (output valid, output pin_a, output pin_b, output pin_key, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input pin_key, output ready);
endinterface

// ===== hw/rtl/reb_out_if.sv =====
// Request channel carrying one scanner result per tick.
interface reb_out_if
    import reb_pkg::*;
;
    logic          valid;
    logic          ready;
    logic          pressed;
    logic          long_held;
    logic          step_cw;
    logic          step_ccw;
    out_position_t x_position;
    out_position_t y_position;
    logic          moved;

    modport source (
        output valid, output pressed, output long_held, output step_cw, output step_ccw,
        output x_position, output y_position, output moved, input ready
    );
    modport sink (
        input valid, input pressed, input long_held, input step_cw, input step_ccw,
        input x_position, input y_position, input moved, output ready
    );
endinterface

// ===== hw/rtl/reb_key.sv =====
// Push-button long-press countdown.
module reb_key
    import reb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   pin_key,
    input  logic [TICKS_WIDTH-1:0] long_press_ticks,
    output key_status_t            status
);

    logic [TICKS_WIDTH-1:0] countdown_reg;
    logic [TICKS_WIDTH-1:0] countdown_next;

    always_comb
    begin
        status.pressed   = (pin_key == KEY_DOWN);
        status.long_held = 1'b0;
        countdown_next   = countdown_reg;
        if (pin_key == KEY_DOWN)
        begin
            if (countdown_reg == '0)
            begin
                status.long_held = 1'b1;
            end
            else
            begin
                countdown_next = countdown_reg - TICKS_WIDTH'(1);
            end
        end
        else
        begin
            countdown_next = long_press_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
        end
        else if (adv)
        begin
            countdown_reg <= countdown_next;
        end
    end

endmodule

// ===== hw/rtl/reb_quad.sv =====
// Channel A edge detection and the two wrapping position counters.
module reb_quad
    import reb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         pin_a,
    input  logic         pin_b,
    input  logic         pressed,
    input  logic         step_on_rising,
    output quad_result_t result
);

    logic      a_last_reg;
    position_t x_count_reg;
    position_t y_count_reg;
    logic      step;
    position_t delta;

    always_comb
    begin
        step            = (pin_a != a_last_reg) && (pin_a == step_on_rising);
        result.step_cw  = step && pin_b;
        result.step_ccw = step && !pin_b;
        result.moved    = step;
        delta           = pin_b ? POSITION_WIDTH'(1) : '1;
        result.x_next   = x_count_reg;
        result.y_next   = y_count_reg;
        if (step)
        begin
            if (pressed)
            begin
                result.y_next = y_count_reg + delta;
            end
            else
            begin
                result.x_next = x_count_reg + delta;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_last_reg  <= A_IDLE_LEVEL;
            x_count_reg <= '0;
            y_count_reg <= '0;
        end
        else if (adv)
        begin
            a_last_reg  <= pin_a;
            x_count_reg <= result.x_next;
            y_count_reg <= result.y_next;
        end
    end

endmodule

// ===== hw/rtl/rotary_encoder_button_scanner.sv =====
// Top level of the rotary encoder and push-button scanner.
//
// Each request on the sample channel is one periodic tick of the encoder pins
// A and B and of the active-low push button. Every sample yields exactly one
// request on the result channel: button state, long-press flag, detent steps
// of this tick, both position counters after the tick, and a moved flag.
// A sample is captured in an input register, decoded by short logic and
// written to the result register, from which the result is offered. One
// sample is taken every clock cycle while the receiver does not stall; the
// rate is set by the single decode pass between the two registers.
// When the receiver stalls, the result register holds, the input register
// takes a sample only while empty, and ready drops until the result moves.
// Reset clears the valid flags of both registers, sets the stored A level
// high, zeroes the countdown and both counters, and loads the configuration
// reset values (long press after 1000 ticks, steps on a falling A edge).
// Configuration writes take effect at the clock edge that carries them.
module rotary_encoder_button_scanner
    import reb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    reb_in_if.sink                    sample,
    reb_out_if.source                 result,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic [TICKS_WIDTH-1:0] long_press_ticks_reg;
    logic                   step_on_rising_reg;

    logic s1_valid_reg;
    logic s1_pin_a_reg;
    logic s1_pin_b_reg;
    logic s1_pin_key_reg;

    logic          out_valid_reg;
    logic          out_pressed_reg;
    logic          out_long_held_reg;
    logic          out_step_cw_reg;
    logic          out_step_ccw_reg;
    out_position_t out_x_reg;
    out_position_t out_y_reg;
    logic          out_moved_reg;

    logic         out_free;
    logic         s1_adv;
    logic         in_fire;
    key_status_t  key_status;
    quad_result_t quad_res;

    assign out_free     = !out_valid_reg || result.ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;
    assign in_fire      = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= LONG_PRESS_RESET;
            step_on_rising_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data[TICKS_WIDTH-1:0];
                CFG_STEP_ON_RISING:   step_on_rising_reg   <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pin_a_reg   <= sample.pin_a;
            s1_pin_b_reg   <= sample.pin_b;
            s1_pin_key_reg <= sample.pin_key;
        end
    end

    reb_key u_key (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (s1_adv),
        .pin_key          (s1_pin_key_reg),
        .long_press_ticks (long_press_ticks_reg),
        .status           (key_status)
    );

    reb_quad u_quad (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (s1_adv),
        .pin_a          (s1_pin_a_reg),
        .pin_b          (s1_pin_b_reg),
        .pressed        (key_status.pressed),
        .step_on_rising (step_on_rising_reg),
        .result         (quad_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pressed_reg   <= key_status.pressed;
            out_long_held_reg <= key_status.long_held;
            out_step_cw_reg   <= quad_res.step_cw;
            out_step_ccw_reg  <= quad_res.step_ccw;
            out_x_reg         <= pos_out(quad_res.x_next);
            out_y_reg         <= pos_out(quad_res.y_next);
            out_moved_reg     <= quad_res.moved;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.pressed    = out_pressed_reg;
    assign result.long_held  = out_long_held_reg;
    assign result.step_cw    = out_step_cw_reg;
    assign result.step_ccw   = out_step_ccw_reg;
    assign result.x_position = out_x_reg;
    assign result.y_position = out_y_reg;
    assign result.moved      = out_moved_reg;

    // A long press is only ever reported for a held button.
    a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_long_held_reg || out_pressed_reg))
        else $error("long_held reported while button released");

    // A moved tick carries exactly one step direction, a quiet tick none.
    a_moved_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_moved_reg == (out_step_cw_reg ^ out_step_ccw_reg))
                          && !(out_step_cw_reg && out_step_ccw_reg))
        else $error("moved flag and step directions disagree");

    // A captured sample is never dropped while the result side is blocked.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_pin_a_reg)
                                          && $stable(s1_pin_key_reg)))
        else $error("input register lost a sample under stall");

endmodule

// ===== bench/scanner_checker.sv =====
// Checker for the encoder scanner: predicts each tick result and compares it with the DUT.
module scanner_checker
    import reb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    reb_in_if                         sample,
    reb_out_if                        result,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        ticks_checked,
    output int                        cw_seen,
    output int                        ccw_seen,
    output int                        long_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          pressed;
        logic          long_held;
        logic          step_cw;
        logic          step_ccw;
        out_position_t x_position;
        out_position_t y_position;
        logic          moved;
    } tick_result_t;

    // Local copy of the scanner state and its two registers.
    logic [TICKS_WIDTH-1:0] press_limit;
    logic                   step_level;
    logic                   a_level;
    logic [TICKS_WIDTH-1:0] countdown;
    position_t              x_count;
    position_t              y_count;

    tick_result_t expected_ticks[$];

    function automatic tick_result_t scan_tick(input logic a, input logic b, input logic key);
        tick_result_t r;
        r = '0;
        if (key == KEY_DOWN) begin
            r.pressed = 1'b1;
            if (countdown == '0)
                r.long_held = 1'b1;
            else
                countdown = countdown - TICKS_WIDTH'(1);
        end
        else begin
            countdown = press_limit;
        end
        if (a != a_level) begin
            if (a == step_level) begin
                if (b)
                    r.step_cw = 1'b1;
                else
                    r.step_ccw = 1'b1;
            end
            a_level = a;
        end
        if (r.step_cw || r.step_ccw) begin
            if (r.pressed)
                y_count = r.step_cw ? y_count + position_t'(1) : y_count - position_t'(1);
            else
                x_count = r.step_cw ? x_count + position_t'(1) : x_count - position_t'(1);
            r.moved = 1'b1;
        end
        // The counters are sign-extended, then cut to the result field width.
        r.x_position = OUT_POS_WIDTH'(x_count);
        r.y_position = OUT_POS_WIDTH'(y_count);
        return r;
    endfunction

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        int           change;
        if (!rst_n) begin
            press_limit   = LONG_PRESS_RESET;
            step_level    = 1'b0;
            a_level       = A_IDLE_LEVEL;
            countdown     = '0;
            x_count       = '0;
            y_count       = '0;
            expected_ticks.delete();
            outstanding   <= 0;
            mismatches    = 0;
            ticks_checked = 0;
            cw_seen       = 0;
            ccw_seen      = 0;
            long_seen     = 0;
        end
        else begin
            change = 0;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LONG_PRESS_TICKS: press_limit = cfg_data[TICKS_WIDTH-1:0];
                    CFG_STEP_ON_RISING:   step_level  = cfg_data[0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready) begin
                expected_ticks.push_back(scan_tick(sample.pin_a, sample.pin_b, sample.pin_key));
                change++;
            end
            if (result.valid && result.ready) begin
                if (expected_ticks.size() == 0) begin
                    report("result request arrived with nothing expected");
                end
                else begin
                    want = expected_ticks.pop_front();
                    change--;
                    ticks_checked++;
                    if (want.step_cw)
                        cw_seen++;
                    if (want.step_ccw)
                        ccw_seen++;
                    if (want.long_held)
                        long_seen++;
                    if (result.pressed !== want.pressed)
                        report($sformatf("pressed expected %0b got %0b",
                                         want.pressed, result.pressed));
                    if (result.long_held !== want.long_held)
                        report($sformatf("long_held expected %0b got %0b",
                                         want.long_held, result.long_held));
                    if (result.step_cw !== want.step_cw)
                        report($sformatf("step_cw expected %0b got %0b",
                                         want.step_cw, result.step_cw));
                    if (result.step_ccw !== want.step_ccw)
                        report($sformatf("step_ccw expected %0b got %0b",
                                         want.step_ccw, result.step_ccw));
                    if (result.x_position !== want.x_position)
                        report($sformatf("x_position expected %0d got %0d",
                                         want.x_position, result.x_position));
                    if (result.y_position !== want.y_position)
                        report($sformatf("y_position expected %0d got %0d",
                                         want.y_position, result.y_position));
                    if (result.moved !== want.moved)
                        report($sformatf("moved expected %0b got %0b",
                                         want.moved, result.moved));
                end
            end
            outstanding <= outstanding + change;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the scanner testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
    import reb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int DETENT_RUN     = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    reb_in_if  sample_ch ();
    reb_out_if result_ch ();

    int mismatches;
    int outstanding;
    int ticks_checked;
    int cw_seen;
    int ccw_seen;
    int long_seen;

    // Stimulus state shared with the receiver process.
    logic offering;
    logic no_idle;
    logic active_level;
    logic key_level;
    logic [1:0] knob_phase;
    int   hold_asks;
    int   hold_served;
    int   hold_left;
    int   stall_left;
    int   samples_sent;
    int   settings_used;
    int   quiet_cycles;

    rotary_encoder_button_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scanner_checker scan_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .result        (result_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .ticks_checked (ticks_checked),
        .cw_seen       (cw_seen),
        .ccw_seen      (ccw_seen),
        .long_seen     (long_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: mostly ready, short stalls now and then, a few long ones,
    // and a long hold-off whenever the stimulus asks for one.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = LONG_HOLD - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (no_idle) begin
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else begin
            case ($urandom_range(0, 99)) inside
                [0:64]:  result_ch.ready <= 1'b1;
                [65:91]: begin
                    stall_left = $urandom_range(0, 2);
                    result_ch.ready <= 1'b0;
                end
                default: begin
                    stall_left = $urandom_range(4, 39);
                    result_ch.ready <= 1'b0;
                end
            endcase
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic a, input logic b, input logic key);
        int gap;
        sample_ch.valid   <= 1'b1;
        sample_ch.pin_a   <= a;
        sample_ch.pin_b   <= b;
        sample_ch.pin_key <= key;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        samples_sent++;
        gap = 0;
        if (!no_idle) begin
            case ($urandom_range(0, 99)) inside
                [0:59]:  gap = 0;
                [60:89]: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(5, 40);
            endcase
        end
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering samples and wait until every result has come back.
    task automatic wait_drained();
        if (offering) begin
            sample_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [TICKS_WIDTH-1:0] ticks, input logic rising);
        wait_drained();
        write_register(CFG_LONG_PRESS_TICKS, CFG_DATA_WIDTH'(ticks));
        write_register(CFG_STEP_ON_RISING, CFG_DATA_WIDTH'(rising));
        active_level = rising;
        settings_used++;
    endtask

    // Mostly clean quadrature turns with random direction changes and
    // button presses, the rest random pin noise.
    task automatic turn_knob(input int count);
        int left;
        int len;
        logic [1:0] dir;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(4, 24);
                dir = $urandom_range(0, 1) ? 2'd1 : 2'd3;
                for (int i = 0; i < len && left > 0; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        dir = -dir;
                    if ($urandom_range(0, 11) == 0)
                        key_level = !key_level;
                    if ($urandom_range(0, 4) != 0)
                        knob_phase = knob_phase + dir;
                    // Gray coding of the phase gives the A and B levels.
                    send_sample(knob_phase[1], knob_phase[1] ^ knob_phase[0], key_level);
                    left--;
                end
            end
            else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len && left > 0; i++) begin
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                    left--;
                end
            end
        end
    endtask

    // A back-to-back run of detents in one direction.
    task automatic detent_run(input logic held, input logic clockwise);
        no_idle = 1'b1;
        for (int i = 0; i < DETENT_RUN; i++) begin
            send_sample(!active_level, clockwise, !held);
            send_sample(active_level, clockwise, !held);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_LONG_PRESS_TICKS;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.pin_a   = 1'b1;
        sample_ch.pin_b   = 1'b1;
        sample_ch.pin_key = 1'b1;
        result_ch.ready   = 1'b0;
        offering          = 1'b0;
        no_idle           = 1'b0;
        active_level      = 1'b0;
        key_level         = 1'b1;
        knob_phase        = 2'd0;
        hold_asks         = 0;
        hold_served       = 0;
        hold_left         = 0;
        stall_left        = 0;
        samples_sent      = 0;
        settings_used     = 1;
        quiet_cycles      = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A press straight after reset finds the countdown at zero.
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);

        // Short countdown with steps on the rising edge of A.
        apply_setting(16'd2, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);

        // Zero limit: long press on the first held tick after a release.
        apply_setting(16'd0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);

        // Largest limit, then a new limit written while the button is held
        // only applies after the next release.
        apply_setting(16'hFFFF, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        apply_setting(16'd1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);

        apply_setting(16'd3, 1'b0);
        turn_knob(85);
        apply_setting(16'd0, 1'b1);
        turn_knob(85);

        // Receiver holds off while samples keep coming, so the input stalls.
        apply_setting(16'hFFFF, 1'b0);
        no_idle = 1'b1;
        hold_asks++;
        turn_knob(40);
        no_idle = 1'b0;
        turn_knob(45);

        apply_setting(16'($urandom_range(1, 25)), 1'b1);
        turn_knob(40);
        wait_drained();
        turn_knob(45);
        apply_setting(16'($urandom_range(0, 40)), 1'b0);
        turn_knob(85);
        apply_setting(16'd10, 1'b1);
        turn_knob(85);
        apply_setting(16'd1, 1'b1);
        turn_knob(85);

        // Unbroken detent runs: counter-clockwise on the x counter, clockwise on the y counter while held.
        apply_setting(16'd5, 1'b0);
        detent_run(1'b0, 1'b0);
        apply_setting(16'd5, 1'b1);
        detent_run(1'b1, 1'b1);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d pin samples under %0d register settings, with one-way detent runs.",
                 samples_sent, settings_used);
        $display("Checked %0d results: %0d clockwise, %0d counter-clockwise, %0d long-press ticks.",
                 ticks_checked, cw_seen, ccw_seen, long_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
